// ===== rtl/core/gnd_pkg.sv =====
// ----------------------------------------------------------------------------
// gnd_pkg
// Shared types, constants and the neighborhood classification function for
// the grid neighborhood diff block.
// ----------------------------------------------------------------------------
package gnd_pkg;

	localparam int GRID_COLS   = 64;
	localparam int GRID_ROWS   = 64;
	localparam int FIELD_LIMIT = 64;
	localparam int COL_LIM     = (GRID_COLS < FIELD_LIMIT) ? GRID_COLS : FIELD_LIMIT;
	localparam int ROW_LIM     = (GRID_ROWS < FIELD_LIMIT) ? GRID_ROWS : FIELD_LIMIT;
	localparam int NB_SPAN     = 3;
	localparam int NB_CELLS    = NB_SPAN * NB_SPAN;
	localparam int COORD_W     = 6;
	localparam int SLOT_W      = $clog2(NB_CELLS);

	typedef logic [COORD_W-1:0]  coord_t;
	typedef logic [NB_CELLS-1:0] nb_mask_t;

	typedef enum logic [1:0] {
		KIND_REMOVE = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_NONE   = 2'd2
	} kind_t;

	// Classified request: which neighborhood slots are reported, plus both centers
	typedef struct packed {
		nb_mask_t rem_mask;
		nb_mask_t add_mask;
		coord_t   old_col;
		coord_t   old_row;
		coord_t   new_col;
		coord_t   new_row;
	} item_t;

	// Slots around (ac,ar) that lie on the grid and not around (bc,br), row-major
	function automatic nb_mask_t nb_mask(coord_t ac, coord_t ar, coord_t bc, coord_t br);
		logic signed [7:0] c;
		logic signed [7:0] r;
		logic signed [7:0] dc;
		logic signed [7:0] dr;
		logic              on_grid;
		logic              near;
		nb_mask_t          m;
		m = '0;
		for (int dy = 0; dy < NB_SPAN; dy++) begin
			for (int dx = 0; dx < NB_SPAN; dx++) begin
				c  = $signed({2'b00, ac}) + $signed(8'(dx)) - 8'sd1;
				r  = $signed({2'b00, ar}) + $signed(8'(dy)) - 8'sd1;
				dc = c - $signed({2'b00, bc});
				dr = r - $signed({2'b00, br});
				on_grid = (c >= 8'sd0) && (r >= 8'sd0) &&
				          (c < $signed(8'(COL_LIM))) && (r < $signed(8'(ROW_LIM)));
				near = (dc >= -8'sd1) && (dc <= 8'sd1) && (dr >= -8'sd1) && (dr <= 8'sd1);
				m[dy*NB_SPAN + dx] = on_grid && !near;
			end
		end
		return m;
	endfunction

endpackage

// ===== rtl/core/gnd_front.sv =====
// ----------------------------------------------------------------------------
// gnd_front
// Accepts requests, works out the remove and add slot masks and hands the
// classified request to the queue.
// ----------------------------------------------------------------------------
module gnd_front import gnd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  coord_t old_col,
	input  coord_t old_row,
	input  coord_t new_col,
	input  coord_t new_row,
	output logic   push_valid,
	input  logic   push_ready,
	output item_t  push_item
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.rem_mask <= nb_mask(old_col, old_row, new_col, new_row);
			item_s1.add_mask <= nb_mask(new_col, new_row, old_col, old_row);
			item_s1.old_col  <= old_col;
			item_s1.old_row  <= old_row;
			item_s1.new_col  <= new_col;
			item_s1.new_row  <= new_row;
		end
	end

endmodule

// ===== rtl/core/gnd_queue.sv =====
// ----------------------------------------------------------------------------
// gnd_queue
// Two-entry queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module gnd_queue import gnd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/gnd_back.sv =====
// ----------------------------------------------------------------------------
// gnd_back
// Walks the slot masks of one request, one result per cycle unless stalled,
// removes first and adds after, into a registered output stage.
// ----------------------------------------------------------------------------
module gnd_back import gnd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pop_valid,
	output logic   pop_ready,
	input  item_t  pop_item,
	output logic   out_valid,
	input  logic   out_ready,
	output kind_t  change_kind,
	output coord_t cell_col,
	output coord_t cell_row,
	output logic   last
);

	logic              busy_q;
	item_t             cur_q;
	logic              out_valid_q;
	kind_t             kind_q;
	coord_t            col_q;
	coord_t            row_q;
	logic              last_q;

	logic              emit_en;
	logic              use_rem;
	nb_mask_t          sel_mask;
	logic [SLOT_W-1:0] slot;
	logic [1:0]        slot_dx;
	logic [1:0]        slot_dy;
	coord_t            base_col;
	coord_t            base_row;
	nb_mask_t          rem_next;
	nb_mask_t          add_next;
	logic              fin;
	kind_t             kind_d;
	coord_t            col_d;
	coord_t            row_d;

	assign emit_en = busy_q && (!out_valid_q || out_ready);
	assign use_rem = (cur_q.rem_mask != '0);
	assign sel_mask = use_rem ? cur_q.rem_mask : cur_q.add_mask;

	// Lowest set slot of the active mask
	always_comb begin
		slot = '0;
		for (int i = NB_CELLS - 1; i >= 0; i--) begin
			if (sel_mask[i]) begin
				slot = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		if (slot >= SLOT_W'(2 * NB_SPAN)) begin
			slot_dy = 2'd2;
		end else if (slot >= SLOT_W'(NB_SPAN)) begin
			slot_dy = 2'd1;
		end else begin
			slot_dy = 2'd0;
		end
		slot_dx = 2'(slot - SLOT_W'(slot_dy) * SLOT_W'(NB_SPAN));
	end

	assign base_col = use_rem ? cur_q.old_col : cur_q.new_col;
	assign base_row = use_rem ? cur_q.old_row : cur_q.new_row;

	always_comb begin
		rem_next = cur_q.rem_mask;
		add_next = cur_q.add_mask;
		if (use_rem) begin
			rem_next[slot] = 1'b0;
		end else begin
			add_next[slot] = 1'b0;
		end
	end

	assign fin = emit_en && (rem_next == '0) && (add_next == '0);

	always_comb begin
		if (sel_mask == '0) begin
			kind_d = KIND_NONE;
			col_d  = '0;
			row_d  = '0;
		end else begin
			kind_d = use_rem ? KIND_REMOVE : KIND_ADD;
			col_d  = base_col + COORD_W'(slot_dx) - COORD_W'(1);
			row_d  = base_row + COORD_W'(slot_dy) - COORD_W'(1);
		end
	end

	// Load the next request when idle or while emitting the final result
	assign pop_ready = !busy_q || fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_ready) begin
				busy_q <= pop_valid;
			end
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cur_q <= pop_item;
		end else if (emit_en) begin
			cur_q.rem_mask <= rem_next;
			cur_q.add_mask <= add_next;
		end
		if (emit_en) begin
			kind_q <= kind_d;
			col_q  <= col_d;
			row_q  <= row_d;
			last_q <= fin;
		end
	end

	assign out_valid   = out_valid_q;
	assign change_kind = kind_q;
	assign cell_col    = col_q;
	assign cell_row    = row_q;
	assign last        = last_q;

endmodule

// ===== rtl/core/grid_neighborhood_diff_top.sv =====
// ----------------------------------------------------------------------------
// grid_neighborhood_diff_top
// Reports the cells that leave and enter the 3x3 neighborhood when a
// position moves from an old to a new grid cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries old and new cell coordinates.
//   Output channel (out_valid/out_ready) carries one result per transfer:
//   removed cells in row-major order, then added cells, last set on the
//   final one; a single result of kind none when nothing differs.
//   Path: an accepted request passes the classifier register, the queue and
//   the sequencer before its first result reaches the output register.
//   Throughput: the result sequencer emits one result per cycle while the
//   output is not stalled; a request yields max(n, 1) results, n up to 18;
//   the next request is loaded in the cycle its predecessor ends, no gap.
//   A two-entry queue plus the classifier stage hold up to three requests
//   while the sequencer works, so in_ready stays high until they fill.
//   When the receiver stalls, the output register holds its result and the
//   sequencer waits; requests are taken until queue and classifier are full.
//   Reset (arst_n low) empties all stages; no memory needs clearing.
// ----------------------------------------------------------------------------
module grid_neighborhood_diff_top import gnd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  coord_t old_col,
	input  coord_t old_row,
	input  coord_t new_col,
	input  coord_t new_row,
	output logic   out_valid,
	input  logic   out_ready,
	output kind_t  change_kind,
	output coord_t cell_col,
	output coord_t cell_row,
	output logic   last
);

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	gnd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.old_col    (old_col),
		.old_row    (old_row),
		.new_col    (new_col),
		.new_row    (new_row),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	gnd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	gnd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.change_kind (change_kind),
		.cell_col    (cell_col),
		.cell_row    (cell_row),
		.last        (last)
	);

`ifndef SYNTHESIS
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && change_kind == KIND_NONE) |-> (last && cell_col == '0 && cell_row == '0))
		else $error("no-change result must be a lone last result at the origin");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (change_kind == KIND_REMOVE || change_kind == KIND_ADD ||
		               change_kind == KIND_NONE))
		else $error("illegal change kind on output");

	a_add_after_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last && change_kind == KIND_ADD) |=>
		(!out_valid || change_kind == KIND_ADD))
		else $error("remove result followed an add within one run");

	a_ready_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!push_valid && !pop_valid) |-> in_ready)
		else $error("input stalled while classifier and queue are empty");
`endif

endmodule
